FILE: rtl/flpa_pkg.sv
package flpa_pkg;

   // number formats
   localparam int FRAC_BITS = 16;
   localparam int ENTRY_W   = FRAC_BITS + 2;
   localparam int ROT_W     = 3 * ENTRY_W;
   localparam int POS_W     = 32;
   localparam int DATA_W    = 64;
   localparam int ADDR_W    = 6;

   // fulcrum frame transform
   localparam int DIFF_W  = POS_W + 1;
   localparam int XPROD_W = ENTRY_W + DIFF_W;
   localparam int VEC_W   = XPROD_W + 2;
   localparam int MAG_W   = VEC_W - 1;

   // normalizer datapath
   localparam int POS_IDX_W = $clog2(MAG_W);
   localparam int NORM_W    = 30;
   localparam int SQ_W      = 2 * NORM_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int QUO_W     = FRAC_BITS + 1;
   localparam int NUM_W     = NORM_W + FRAC_BITS + 2;
   localparam int DEN_W     = ROOT_W + 1;

   // cross product and output rotation
   localparam int CPROD_W = 2 * ENTRY_W;
   localparam int ACC_W   = CPROD_W + 2;
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(2 ** (ENTRY_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-(2 ** (ENTRY_W - 1)));
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

   // pipeline depths
   localparam int UNIT_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;
   localparam int XF_LAT    = 3;
   localparam int CROSS_LAT = 2;
   localparam int FIN_LAT   = 2;
   localparam int ZX_LAT    = CROSS_LAT + UNIT_LAT;
   localparam int TOTAL_LAT = XF_LAT + 2 * UNIT_LAT + CROSS_LAT + FIN_LAT;

   // register indexes
   localparam logic [2:0] REG_ROT_ROW0 = 3'd0;
   localparam logic [2:0] REG_ROT_ROW1 = 3'd1;
   localparam logic [2:0] REG_ROT_ROW2 = 3'd2;
   localparam logic [2:0] REG_FULCRUM_X = 3'd3;
   localparam logic [2:0] REG_FULCRUM_Y = 3'd4;
   localparam logic [2:0] REG_FULCRUM_Z = 3'd5;

   typedef logic [2:0][POS_W-1:0]   pos3_type;
   typedef logic [2:0][ROT_W-1:0]   rows_type;
   typedef logic [2:0][VEC_W-1:0]   vec_type;
   typedef logic [2:0][ENTRY_W-1:0] dir_type;

   typedef struct packed {
      dir_type x;
      dir_type z;
      logic    ok;
   } axes_type;

   // entry k of a packed rotation row
   function automatic logic [ENTRY_W-1:0] rot_entry(input logic [ROT_W-1:0] row, input int k);
      return row[ENTRY_W*k +: ENTRY_W];
   endfunction

   // position of the highest set bit
   function automatic logic [POS_IDX_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
      logic [POS_IDX_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            pos = POS_IDX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: rtl/flpa_xform.sv
module flpa_xform (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  flpa_pkg::pos3_type in_target,
   input  flpa_pkg::rows_type in_rows,
   input  flpa_pkg::pos3_type in_origin,
   output logic               out_valid,
   output flpa_pkg::vec_type  out_vec
);
   import flpa_pkg::*;

   logic [XF_LAT-1:0] vld_ff;

   logic signed [DIFF_W-1:0]  d_in [3];
   logic signed [DIFF_W-1:0]  d_ff [3];
   logic signed [ENTRY_W-1:0] ent [3][3];
   logic signed [XPROD_W-1:0] prod_in [3][3];
   logic signed [XPROD_W-1:0] prod_ff [3][3];
   logic signed [VEC_W-1:0]   p_in [3];
   logic signed [VEC_W-1:0]   p_ff [3];

   // offset from fulcrum, then rotate by the transpose
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = $signed(in_target[i]) - $signed(in_origin[i]);
         for (int j = 0; j < 3; j++) begin
            ent[i][j] = $signed(rot_entry(in_rows[i], j));
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = ent[j][i] * d_ff[j];
         end
         p_in[i] = prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[XF_LAT-2:0], in_valid};
      end
      d_ff    <= d_in;
      prod_ff <= prod_in;
      p_ff    <= p_in;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_vec[i] = p_ff[i];
      end
   end

   assign out_valid = vld_ff[XF_LAT-1];

endmodule

FILE: rtl/flpa_unit.sv
module flpa_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  flpa_pkg::vec_type in_vec,
   output logic              out_valid,
   output flpa_pkg::dir_type out_dir,
   output logic              out_ok
);
   import flpa_pkg::*;

   logic [UNIT_LAT-1:0] vld_ff;

   // stage a: magnitudes
   logic [VEC_W-1:0] a_negated [3];
   logic [MAG_W-1:0] a_mag_in [3];
   logic [MAG_W-1:0] a_mag_ff [3];
   logic [2:0]       a_neg_ff;

   // stage b: leading one of the largest magnitude
   logic [POS_IDX_W-1:0] b_pos_ff;
   logic                 b_zero_ff;
   logic [MAG_W-1:0]     b_mag_ff [3];
   logic [2:0]           b_neg_ff;

   // stage c: common scaling shift
   logic [NORM_W-1:0] c_norm_in [3];
   logic [NORM_W-1:0] c_norm_ff [3];
   logic [2:0]        c_neg_ff;
   logic              c_zero_ff;

   // stage d: squares
   logic [SQ_W-1:0]   d_sq_ff [3];
   logic [NORM_W-1:0] d_norm_ff [3];
   logic [2:0]        d_neg_ff;
   logic              d_zero_ff;

   // square root steps, index 0 holds the sum of squares
   logic [SUM_W-1:0]  r_s_ff    [ROOT_W+1];
   logic [REM_W-1:0]  r_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] r_root_ff [ROOT_W+1];
   logic [NORM_W-1:0] r_norm_ff [ROOT_W+1][3];
   logic [2:0]        r_neg_ff  [ROOT_W+1];
   logic              r_zero_ff [ROOT_W+1];
   logic [REM_W+1:0]  r_shift   [ROOT_W];
   logic [REM_W+1:0]  r_trial   [ROOT_W];
   logic [REM_W-1:0]  r_rem_in  [ROOT_W];
   logic [ROOT_W-1:0] r_root_in [ROOT_W];

   // division steps, index 0 holds numerator and denominator
   logic [NUM_W-1:0] q_num [3];
   logic [DEN_W-1:0] q_rem_ff [QUO_W+1][3];
   logic [QUO_W-1:0] q_low_ff [QUO_W+1][3];
   logic [QUO_W-1:0] q_quo_ff [QUO_W+1][3];
   logic [DEN_W-1:0] q_den_ff [QUO_W+1];
   logic [2:0]       q_neg_ff [QUO_W+1];
   logic             q_zero_ff [QUO_W+1];
   logic [DEN_W:0]   q_trial  [QUO_W][3];
   logic [DEN_W-1:0] q_rem_in [QUO_W][3];
   logic [QUO_W-1:0] q_quo_in [QUO_W][3];

   // output stage
   dir_type o_dir_in;
   dir_type o_dir_ff;
   logic    o_ok_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_negated[i] = VEC_W'(0) - in_vec[i];
         a_mag_in[i]  = in_vec[i][VEC_W-1] ? a_negated[i][MAG_W-1:0] : in_vec[i][MAG_W-1:0];
      end
   end

   // scale so the largest magnitude lands just below the top of the norm range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (b_pos_ff >= POS_IDX_W'(NORM_W)) begin
            c_norm_in[i] = NORM_W'(b_mag_ff[i] >> (b_pos_ff - POS_IDX_W'(NORM_W - 1)));
         end else begin
            c_norm_in[i] = NORM_W'(b_mag_ff[i] << (POS_IDX_W'(NORM_W - 1) - b_pos_ff));
         end
      end
   end

   // one root bit per stage, two radicand bits consumed
   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         r_shift[k] = {r_rem_ff[k], r_s_ff[k][SUM_W-1 -: 2]};
         r_trial[k] = (REM_W+2)'({r_root_ff[k], 2'b01});
         if (r_shift[k] >= r_trial[k]) begin
            r_rem_in[k]  = REM_W'(r_shift[k] - r_trial[k]);
            r_root_in[k] = {r_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            r_rem_in[k]  = REM_W'(r_shift[k]);
            r_root_in[k] = {r_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // numerator carries the half-unit rounding term
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_num[i] = (NUM_W'(r_norm_ff[ROOT_W][i]) << (FRAC_BITS + 1))
                  + NUM_W'(r_root_ff[ROOT_W]);
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < QUO_W; k++) begin
         for (int i = 0; i < 3; i++) begin
            q_trial[k][i] = {q_rem_ff[k][i], q_low_ff[k][i][QUO_W-1]};
            if (q_trial[k][i] >= {1'b0, q_den_ff[k]}) begin
               q_rem_in[k][i] = DEN_W'(q_trial[k][i] - {1'b0, q_den_ff[k]});
               q_quo_in[k][i] = {q_quo_ff[k][i][QUO_W-2:0], 1'b1};
            end else begin
               q_rem_in[k][i] = q_trial[k][i][DEN_W-1:0];
               q_quo_in[k][i] = {q_quo_ff[k][i][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // restore signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (q_neg_ff[QUO_W][i]) begin
            o_dir_in[i] = ENTRY_W'(0) - ENTRY_W'(q_quo_ff[QUO_W][i]);
         end else begin
            o_dir_in[i] = ENTRY_W'(q_quo_ff[QUO_W][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[UNIT_LAT-2:0], in_valid};
      end

      a_mag_ff <= a_mag_in;
      for (int i = 0; i < 3; i++) begin
         a_neg_ff[i] <= in_vec[i][VEC_W-1];
      end

      b_pos_ff  <= msb_pos(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
      b_zero_ff <= (a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]) == '0;
      b_mag_ff  <= a_mag_ff;
      b_neg_ff  <= a_neg_ff;

      c_norm_ff <= c_norm_in;
      c_neg_ff  <= b_neg_ff;
      c_zero_ff <= b_zero_ff;

      for (int i = 0; i < 3; i++) begin
         d_sq_ff[i] <= SQ_W'(c_norm_ff[i]) * SQ_W'(c_norm_ff[i]);
      end
      d_norm_ff <= c_norm_ff;
      d_neg_ff  <= c_neg_ff;
      d_zero_ff <= c_zero_ff;

      r_s_ff[0]    <= SUM_W'(d_sq_ff[0]) + SUM_W'(d_sq_ff[1]) + SUM_W'(d_sq_ff[2]);
      r_rem_ff[0]  <= '0;
      r_root_ff[0] <= '0;
      r_norm_ff[0] <= d_norm_ff;
      r_neg_ff[0]  <= d_neg_ff;
      r_zero_ff[0] <= d_zero_ff;
      for (int k = 0; k < ROOT_W; k++) begin
         r_s_ff[k+1]    <= r_s_ff[k] << 2;
         r_rem_ff[k+1]  <= r_rem_in[k];
         r_root_ff[k+1] <= r_root_in[k];
         r_norm_ff[k+1] <= r_norm_ff[k];
         r_neg_ff[k+1]  <= r_neg_ff[k];
         r_zero_ff[k+1] <= r_zero_ff[k];
      end

      for (int i = 0; i < 3; i++) begin
         q_rem_ff[0][i] <= DEN_W'(q_num[i][NUM_W-1:QUO_W]);
         q_low_ff[0][i] <= q_num[i][QUO_W-1:0];
         q_quo_ff[0][i] <= '0;
      end
      q_den_ff[0]  <= {r_root_ff[ROOT_W], 1'b0};
      q_neg_ff[0]  <= r_neg_ff[ROOT_W];
      q_zero_ff[0] <= r_zero_ff[ROOT_W];
      for (int k = 0; k < QUO_W; k++) begin
         for (int i = 0; i < 3; i++) begin
            q_rem_ff[k+1][i] <= q_rem_in[k][i];
            q_low_ff[k+1][i] <= q_low_ff[k][i] << 1;
            q_quo_ff[k+1][i] <= q_quo_in[k][i];
         end
         q_den_ff[k+1]  <= q_den_ff[k];
         q_neg_ff[k+1]  <= q_neg_ff[k];
         q_zero_ff[k+1] <= q_zero_ff[k];
      end

      o_dir_ff <= o_dir_in;
      o_ok_ff  <= !q_zero_ff[QUO_W];
   end

   assign out_valid = vld_ff[UNIT_LAT-1];
   assign out_dir   = o_dir_ff;
   assign out_ok    = o_ok_ff;

endmodule

FILE: rtl/flpa_rotate.sv
module flpa_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_ok,
   input  flpa_pkg::dir_type  in_x,
   input  flpa_pkg::dir_type  in_y,
   input  flpa_pkg::dir_type  in_z,
   input  flpa_pkg::rows_type in_rows,
   output logic               out_strobe,
   output flpa_pkg::rows_type out_cols,
   output logic               out_degenerate
);
   import flpa_pkg::*;

   logic [FIN_LAT-1:0] vld_ff;
   logic               ok_ff;

   logic signed [ENTRY_W-1:0] ent [3][3];
   logic signed [ENTRY_W-1:0] ax [3][3];
   logic signed [CPROD_W-1:0] prod_in [3][3][3];
   logic signed [CPROD_W-1:0] prod_ff [3][3][3];
   logic signed [ACC_W-1:0]   acc [3][3];
   logic signed [ACC_W-1:0]   rnd [3][3];
   logic signed [ACC_W-1:0]   shf [3][3];
   logic [ENTRY_W-1:0]        sat [3][3];
   rows_type                  col_in;
   rows_type                  col_ff;
   logic                      degen_ff;

   // products of rotation rows with each axis column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[0][i] = $signed(in_x[i]);
         ax[1][i] = $signed(in_y[i]);
         ax[2][i] = $signed(in_z[i]);
         for (int j = 0; j < 3; j++) begin
            ent[i][j] = $signed(rot_entry(in_rows[i], j));
         end
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_in[c][i][j] = ent[i][j] * ax[c][j];
            end
         end
      end
   end

   // sum, round half up, saturate; zero the columns when not ok
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 3; i++) begin
            acc[c][i] = prod_ff[c][i][0] + prod_ff[c][i][1] + prod_ff[c][i][2];
            rnd[c][i] = acc[c][i] + ROUND_HALF;
            shf[c][i] = rnd[c][i] >>> FRAC_BITS;
            if (shf[c][i] > ACC_MAX) begin
               sat[c][i] = ACC_MAX[ENTRY_W-1:0];
            end else if (shf[c][i] < ACC_MIN) begin
               sat[c][i] = ACC_MIN[ENTRY_W-1:0];
            end else begin
               sat[c][i] = shf[c][i][ENTRY_W-1:0];
            end
            col_in[c][ENTRY_W*i +: ENTRY_W] = ok_ff ? sat[c][i] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FIN_LAT-2:0], in_valid};
      end
      prod_ff  <= prod_in;
      ok_ff    <= in_ok;
      col_ff   <= col_in;
      degen_ff <= !ok_ff;
   end

   assign out_strobe     = vld_ff[FIN_LAT-1];
   assign out_cols       = col_ff;
   assign out_degenerate = degen_ff;

endmodule

FILE: rtl/fulcrum_look_at_pose_core.sv
// the result strobe follows the transform, two normalizers in series, cross product and rotation
// throughput: one target per cycle, busy is never raised
// depth is set by two normalizers in series, each a bit-per-stage root and divide
// reset clears all valid bits and loads the identity rotation and a zero origin
// results are shown for one cycle; the receiver cannot stall them
module fulcrum_look_at_pose_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [flpa_pkg::POS_W-1:0]    req_target_x,
   input  logic [flpa_pkg::POS_W-1:0]    req_target_y,
   input  logic [flpa_pkg::POS_W-1:0]    req_target_z,
   output logic                          rsp_strobe,
   output logic [flpa_pkg::ROT_W-1:0]    rsp_axis_x_col,
   output logic [flpa_pkg::ROT_W-1:0]    rsp_axis_y_col,
   output logic [flpa_pkg::ROT_W-1:0]    rsp_axis_z_col,
   output logic [flpa_pkg::POS_W-1:0]    rsp_pose_x,
   output logic [flpa_pkg::POS_W-1:0]    rsp_pose_y,
   output logic [flpa_pkg::POS_W-1:0]    rsp_pose_z,
   output logic                          rsp_degenerate,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [flpa_pkg::ADDR_W-1:0]   paddr,
   input  logic [flpa_pkg::DATA_W-1:0]   pwdata,
   output logic [flpa_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import flpa_pkg::*;

   logic [ROT_W-1:0] rot_row_ff [3];
   logic [POS_W-1:0] org_ff [3];
   logic [2:0]       csr_index;
   rows_type         rows;
   pos3_type         origin;
   pos3_type         target;

   logic    xf_valid;
   vec_type p_vec;
   vec_type xd_vec;

   logic    z_valid, x_valid, y_valid;
   dir_type z_dir, x_dir, y_dir;
   logic    z_ok, x_ok, y_ok;

   logic signed [ENTRY_W-1:0] zs [3];
   logic signed [ENTRY_W-1:0] xs [3];
   logic signed [CPROD_W-1:0] cp_in [6];
   logic signed [CPROD_W-1:0] cp_ff [6];
   logic signed [VEC_W-1:0]   cr_in [3];
   logic signed [VEC_W-1:0]   cr_ff [3];
   logic [CROSS_LAT-1:0]      cr_vld_ff;
   vec_type                   cr_vec;

   pos3_type tgt_dly_ff [TOTAL_LAT];
   axes_type zx_dly_ff  [ZX_LAT];
   axes_type zx_now;

   rows_type cols;

   // configuration registers
   assign csr_index = paddr[ADDR_W-1:3];
   assign pready    = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            rot_row_ff[i] <= ROT_W'(2 ** FRAC_BITS) << (ENTRY_W * i);
            org_ff[i]     <= '0;
         end
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_index)
            REG_ROT_ROW0:  rot_row_ff[0] <= pwdata[ROT_W-1:0];
            REG_ROT_ROW1:  rot_row_ff[1] <= pwdata[ROT_W-1:0];
            REG_ROT_ROW2:  rot_row_ff[2] <= pwdata[ROT_W-1:0];
            REG_FULCRUM_X: org_ff[0]     <= pwdata[POS_W-1:0];
            REG_FULCRUM_Y: org_ff[1]     <= pwdata[POS_W-1:0];
            REG_FULCRUM_Z: org_ff[2]     <= pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROT_ROW0:  prdata = DATA_W'(rot_row_ff[0]);
         REG_ROT_ROW1:  prdata = DATA_W'(rot_row_ff[1]);
         REG_ROT_ROW2:  prdata = DATA_W'(rot_row_ff[2]);
         REG_FULCRUM_X: prdata = DATA_W'(org_ff[0]);
         REG_FULCRUM_Y: prdata = DATA_W'(org_ff[1]);
         REG_FULCRUM_Z: prdata = DATA_W'(org_ff[2]);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rows[i]   = rot_row_ff[i];
         origin[i] = org_ff[i];
      end
      target[0] = req_target_x;
      target[1] = req_target_y;
      target[2] = req_target_z;
   end

   // target in the fulcrum frame
   flpa_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_target (target),
      .in_rows   (rows),
      .in_origin (origin),
      .out_valid (xf_valid),
      .out_vec   (p_vec)
   );

   // horizontal direction (p2, 0, -p0)
   always_comb begin
      xd_vec[0] = p_vec[2];
      xd_vec[1] = '0;
      xd_vec[2] = VEC_W'(0) - p_vec[0];
   end

   flpa_unit u_unit_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_vec    (p_vec),
      .out_valid (z_valid),
      .out_dir   (z_dir),
      .out_ok    (z_ok)
   );

   flpa_unit u_unit_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_vec    (xd_vec),
      .out_valid (x_valid),
      .out_dir   (x_dir),
      .out_ok    (x_ok)
   );

   // cross product z x x
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         zs[i] = $signed(z_dir[i]);
         xs[i] = $signed(x_dir[i]);
      end
      cp_in[0] = zs[1] * xs[2];
      cp_in[1] = zs[2] * xs[1];
      cp_in[2] = zs[2] * xs[0];
      cp_in[3] = zs[0] * xs[2];
      cp_in[4] = zs[0] * xs[1];
      cp_in[5] = zs[1] * xs[0];
      cr_in[0] = cp_ff[0] - cp_ff[1];
      cr_in[1] = cp_ff[2] - cp_ff[3];
      cr_in[2] = cp_ff[4] - cp_ff[5];
      for (int i = 0; i < 3; i++) begin
         cr_vec[i] = cr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_vld_ff <= '0;
      end else begin
         cr_vld_ff <= {cr_vld_ff[CROSS_LAT-2:0], z_valid && x_valid};
      end
      cp_ff <= cp_in;
      cr_ff <= cr_in;
   end

   flpa_unit u_unit_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_vld_ff[CROSS_LAT-1]),
      .in_vec    (cr_vec),
      .out_valid (y_valid),
      .out_dir   (y_dir),
      .out_ok    (y_ok)
   );

   // side lines aligned with the pipeline
   assign zx_now = '{x: x_dir, z: z_dir, ok: z_ok && x_ok};

   always_ff @(posedge clock) begin
      tgt_dly_ff[0] <= target;
      for (int k = 1; k < TOTAL_LAT; k++) begin
         tgt_dly_ff[k] <= tgt_dly_ff[k-1];
      end
      zx_dly_ff[0] <= zx_now;
      for (int k = 1; k < ZX_LAT; k++) begin
         zx_dly_ff[k] <= zx_dly_ff[k-1];
      end
   end

   flpa_rotate u_rotate (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (y_valid),
      .in_ok          (zx_dly_ff[ZX_LAT-1].ok && y_ok),
      .in_x           (zx_dly_ff[ZX_LAT-1].x),
      .in_y           (y_dir),
      .in_z           (zx_dly_ff[ZX_LAT-1].z),
      .in_rows        (rows),
      .out_strobe     (rsp_strobe),
      .out_cols       (cols),
      .out_degenerate (rsp_degenerate)
   );

   assign rsp_axis_x_col = cols[0];
   assign rsp_axis_y_col = cols[1];
   assign rsp_axis_z_col = cols[2];
   assign rsp_pose_x     = tgt_dly_ff[TOTAL_LAT-1][0];
   assign rsp_pose_y     = tgt_dly_ff[TOTAL_LAT-1][1];
   assign rsp_pose_z     = tgt_dly_ff[TOTAL_LAT-1][2];

endmodule
